/* hw/rtl/crr_pkg.sv */
// shared constants, types and helper functions for the region recolor block
package crr_pkg;

  localparam int NumParts     = 7;
  localparam int ColorW       = 24;
  localparam int CfgIdxW      = 3;
  localparam int EndpointW    = 16;
  localparam int IndexW       = 32;
  localparam int CoordW       = 6;

  // register map
  localparam logic [CfgIdxW-1:0] RegPartEnable = 3'd7;

  // part codes
  localparam logic [2:0] Part0 = 3'd0;
  localparam logic [2:0] Part1 = 3'd1;
  localparam logic [2:0] Part2 = 3'd2;
  localparam logic [2:0] Part3 = 3'd3;
  localparam logic [2:0] Part4 = 3'd4;
  localparam logic [2:0] Part6 = 3'd6;

  // region bounds in pixels
  localparam logic [7:0] YLow      = 8'd160;
  localparam logic [7:0] YHigh     = 8'd208;
  localparam logic [7:0] XEast     = 8'd192;
  localparam logic [7:0] XMid      = 8'd128;
  localparam logic [7:0] XWest     = 8'd64;
  localparam logic [7:0] YTop      = 8'd64;
  localparam logic [7:0] YPart6    = 8'd100;
  localparam logic [9:0] SumFloor  = 10'd96;

  localparam logic [21:0] ScaleDiv = 22'd65025;

  typedef logic [NumParts-1:0][ColorW-1:0] part_colors_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctrl_t;

  // floor(v*255/31) = 8v + floor(7v/31)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] n;
    logic [2:0] q0;
    logic [7:0] rem;
    n   = 8'(v) * 8'd7;
    q0  = n[7:5];
    rem = n - 8'(q0) * 8'd31;
    expand5 = {v, 3'b000} + 8'(q0) + ((rem >= 8'd31) ? 8'd1 : 8'd0);
  endfunction

  // floor(v*255/63) = 4v + floor(v/21)
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [1:0] q;
    q = 2'((v >= 6'd21) ? 1 : 0) + 2'((v >= 6'd42) ? 1 : 0) + 2'((v == 6'd63) ? 1 : 0);
    expand6 = {v, 2'b00} + 8'(q);
  endfunction

  // floor(n/65025) for n below 4161600 (64 * 65025); n>>16 is short by at most one
  function automatic logic [5:0] div_scale(input logic [21:0] n);
    logic [5:0]  q0;
    logic [21:0] rem;
    q0  = n[21:16];
    rem = n - 22'(q0) * ScaleDiv;
    div_scale = q0 + ((rem >= ScaleDiv) ? 6'd1 : 6'd0);
  endfunction

endpackage

/* hw/rtl/crr_if.sv */
// channel interfaces: input block, output block and configuration writes
interface crr_in_if import crr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [EndpointW-1:0] endpoint_a;
  logic [EndpointW-1:0] endpoint_b;
  logic [IndexW-1:0]    index_rows;
  logic [CoordW-1:0]    block_col;
  logic [CoordW-1:0]    block_row;
  modport source (output valid, endpoint_a, endpoint_b, index_rows, block_col, block_row,
                  input ready);
  modport sink   (input valid, endpoint_a, endpoint_b, index_rows, block_col, block_row,
                  output ready);
endinterface

interface crr_out_if import crr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [EndpointW-1:0] out_endpoint_a;
  logic [EndpointW-1:0] out_endpoint_b;
  logic [IndexW-1:0]    out_index_rows;
  modport source (output valid, out_endpoint_a, out_endpoint_b, out_index_rows, input ready);
  modport sink   (input valid, out_endpoint_a, out_endpoint_b, out_index_rows, output ready);
endinterface

interface crr_cfg_if import crr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ColorW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/crr_lane.sv */
// one endpoint lane: expand, classify, pick part, scale part colour by brightness
module crr_lane import crr_pkg::*; (
  input  logic                 clk,
  input  lane_ctrl_t           ctrl,
  input  logic [EndpointW-1:0] endpoint,
  input  logic [CoordW-1:0]    block_col,
  input  logic [CoordW-1:0]    block_row,
  input  part_colors_t         part_colors,
  input  logic [NumParts-1:0]  part_enable,
  output logic [EndpointW-1:0] tinted
);

  logic [7:0] r, g, b, x, y, light, rg_max;
  logic [8:0] r15, g15, b15;
  logic       red, blue, yellow;
  logic [9:0] sum;
  logic [2:0] part;
  logic       found;
  logic [ColorW-1:0] color;

  // stage 1 registers
  logic [EndpointW-1:0] v1;
  logic                 hit1;
  logic [7:0]           light1, pr1, pg1, pb1;
  // stage 2 registers
  logic [EndpointW-1:0] v2;
  logic                 hit2;
  logic [21:0]          nr2, ng2, nb2;

  logic [15:0] prod_r, prod_g, prod_b;
  logic [5:0]  qr, qg, qb;

  always_comb begin
    r   = expand5(endpoint[15:11]);
    g   = expand6(endpoint[10:5]);
    b   = expand5(endpoint[4:0]);
    r15 = 9'((10'(r) * 10'd3) >> 1);
    g15 = 9'((10'(g) * 10'd3) >> 1);
    b15 = 9'((10'(b) * 10'd3) >> 1);
    red    = (9'(r) > g15) && (9'(r) > b15);
    blue   = (9'(b) > r15) && (b > g);
    yellow = (9'(r) > b15) && (9'(g) > b15);
    sum    = 10'(r) + 10'(g) + 10'(b);
    x = {block_col, 2'b00};
    y = {block_row, 2'b00};
    part  = Part0;
    found = 1'b0;
    if (y >= YLow) begin
      if (x >= XEast) begin
        found = red;
        part  = Part0;
      end else if (x >= XMid) begin
        found = 1'b1;
        part  = Part3;
      end else if (x < XWest) begin
        found = 1'b1;
        part  = Part4;
      end else if (y < YHigh) begin
        found = 1'b1;
        part  = Part1;
      end
    end else if (x < XMid) begin
      if (blue) begin
        found = 1'b1;
        part  = Part2;
      end else if (y < YTop && red) begin
        found = 1'b1;
        part  = Part1;
      end
    end else if (x >= XEast && y >= YPart6) begin
      found = !yellow && (sum > SumFloor);
      part  = Part6;
    end
    rg_max = (r > g) ? r : g;
    light  = (b > rg_max) ? b : rg_max;
    color  = part_colors[part];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      v1     <= endpoint;
      hit1   <= found && part_enable[part];
      light1 <= light;
      pr1    <= color[23:16];
      pg1    <= color[15:8];
      pb1    <= color[7:0];
    end
  end

  always_comb begin
    prod_r = 16'(pr1) * 16'(light1);
    prod_g = 16'(pg1) * 16'(light1);
    prod_b = 16'(pb1) * 16'(light1);
  end

  // times 31 and 63 as shift and subtract
  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      v2   <= v1;
      hit2 <= hit1;
      nr2  <= (22'(prod_r) << 5) - 22'(prod_r);
      ng2  <= (22'(prod_g) << 6) - 22'(prod_g);
      nb2  <= (22'(prod_b) << 5) - 22'(prod_b);
    end
  end

  always_comb begin
    qr = div_scale(nr2);
    qg = div_scale(ng2);
    qb = div_scale(nb2);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      tinted <= hit2 ? {qr[4:0], qg, qb[4:0]} : v2;
    end
  end

endmodule

/* hw/rtl/crr_merge.sv */
// merge of both lanes: reorder endpoints, separate equal ones in four-colour mode, remap indices on a swap
module crr_merge import crr_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [EndpointW-1:0] tint_a,
  input  logic [EndpointW-1:0] tint_b,
  input  logic                 four,
  input  logic [IndexW-1:0]    index_rows,
  output logic [EndpointW-1:0] out_a,
  output logic [EndpointW-1:0] out_b,
  output logic [IndexW-1:0]    out_rows
);

  logic                 swap;
  logic [EndpointW-1:0] sa, sb, na, nb;
  logic [IndexW-1:0]    mapped;

  always_comb begin
    swap = four ? (tint_a < tint_b) : (tint_a > tint_b);
    sa   = swap ? tint_b : tint_a;
    sb   = swap ? tint_a : tint_b;
    na   = sa;
    nb   = sb;
    if (four && sa == sb) begin
      if (sa != {EndpointW{1'b1}}) na = sa + 1'b1;
      else                         nb = sb - 1'b1;
    end
    // three-colour mode leaves indices 2 and 3 alone
    for (int k = 0; k < IndexW / 2; k++) begin
      mapped[2*k+1] = index_rows[2*k+1];
      mapped[2*k]   = index_rows[2*k] ^ (four || !index_rows[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a    <= na;
      out_b    <= nb;
      out_rows <= swap ? mapped : index_rows;
    end
  end

endmodule

/* hw/rtl/compressed_block_region_recolor.sv */
// top level of the compressed block region recolor pipeline
//
// blk_in carries one 4x4 sub-block per transfer: both RGB565 endpoints, the
// four index bytes and the sub-block column and row in the atlas. blk_out
// returns one result per input, in order: the recolored and reordered
// endpoints and the index bytes, remapped when the endpoints swapped.
// cfg writes the seven part colours (index 0 to 6) and the part enable mask
// (index 7); it is always ready and takes every write.
// an input transfer passes through three stages in each of the two endpoint
// lanes (expand and region pick, brightness multiply, divide correction) and
// then the merge register before its result is offered on blk_out.
// one sub-block is taken every cycle while blk_out drains.
// each stage holds when the stage after it is full and stalled, so a
// stalled receiver fills the four stages and then blk_in.ready drops;
// bubbles ahead of a stall are squeezed out.
// a synchronous rst empties the pipeline and clears all part colours and
// the enable mask.
module compressed_block_region_recolor import crr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  crr_in_if.sink    blk_in,
  crr_out_if.source blk_out,
  crr_cfg_if.sink   cfg
);

  part_colors_t        part_colors;
  logic [NumParts-1:0] part_enable;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  lane_ctrl_t ctrl;

  logic              four1, four2, four3;
  logic [IndexW-1:0] rows1, rows2, rows3;
  logic [EndpointW-1:0] tint_a, tint_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_colors <= '0;
      part_enable <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == RegPartEnable) part_enable <= cfg.data[NumParts-1:0];
      else                            part_colors[cfg.index] <= cfg.data;
    end
  end

  always_comb begin
    rdy4 = !v4 || blk_out.ready;
    rdy3 = !v3 || rdy4;
    rdy2 = !v2 || rdy3;
    rdy1 = !v1 || rdy2;
    ctrl.en1 = rdy1;
    ctrl.en2 = rdy2;
    ctrl.en3 = rdy3;
  end

  assign blk_in.ready  = rdy1;
  assign blk_out.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= blk_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // mode and index bytes ride alongside the lanes
  always_ff @(posedge clk) begin
    if (rdy1) begin
      four1 <= blk_in.endpoint_a > blk_in.endpoint_b;
      rows1 <= blk_in.index_rows;
    end
    if (rdy2) begin
      four2 <= four1;
      rows2 <= rows1;
    end
    if (rdy3) begin
      four3 <= four2;
      rows3 <= rows2;
    end
  end

  crr_lane u_lane_a (
    .clk         (clk),
    .ctrl        (ctrl),
    .endpoint    (blk_in.endpoint_a),
    .block_col   (blk_in.block_col),
    .block_row   (blk_in.block_row),
    .part_colors (part_colors),
    .part_enable (part_enable),
    .tinted      (tint_a)
  );

  crr_lane u_lane_b (
    .clk         (clk),
    .ctrl        (ctrl),
    .endpoint    (blk_in.endpoint_b),
    .block_col   (blk_in.block_col),
    .block_row   (blk_in.block_row),
    .part_colors (part_colors),
    .part_enable (part_enable),
    .tinted      (tint_b)
  );

  crr_merge u_merge (
    .clk        (clk),
    .en         (rdy4),
    .tint_a     (tint_a),
    .tint_b     (tint_b),
    .four       (four3),
    .index_rows (rows3),
    .out_a      (blk_out.out_endpoint_a),
    .out_b      (blk_out.out_endpoint_b),
    .out_rows   (blk_out.out_index_rows)
  );

endmodule

/* hw/rtl/crr_chk.sv */
// port-level checker for the region recolor block, bound to the top level
module crr_chk import crr_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [EndpointW-1:0] out_a,
  input logic [EndpointW-1:0] out_b,
  input logic [IndexW-1:0]    out_rows
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b)
      && $stable(out_rows))
    else $error("stalled result changed or dropped");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up when the output is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // an accepted item or one ahead of it later reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##4 out_valid)
    else $error("no result at the output after accepted transfer");

endmodule

bind compressed_block_region_recolor crr_chk u_crr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (blk_in.valid),
  .in_ready  (blk_in.ready),
  .out_valid (blk_out.valid),
  .out_ready (blk_out.ready),
  .out_a     (blk_out.out_endpoint_a),
  .out_b     (blk_out.out_endpoint_b),
  .out_rows  (blk_out.out_index_rows)
);
